[design/tds_pkg.sv]
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants of the TDS ppm converter
// Fixed-point widths, polynomial coefficients, register indexes and the
// derived configuration bundle passed from the register block to the datapath.
// ----------------------------------------------------------------------------
package tds_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_IDX_TEMP = t_cfg_index'(0);
    localparam t_cfg_index CFG_IDX_CAL  = t_cfg_index'(1);

    // register fields
    localparam int TEMP_W = 10;
    localparam int CAL_W  = 16;
    localparam logic [TEMP_W-1:0] TEMP_RESET = 10'd250;
    localparam logic [TEMP_W-1:0] TEMP_MAX   = 10'd800;
    localparam logic [CAL_W-1:0]  CAL_ONE    = 16'd4096;
    localparam logic [CAL_W-1:0]  CAL_MAX    = 16'd40960;

    // Q.16 formats
    localparam int FRAC_W = 16;
    localparam int VOLT_W = 18;   // up to 3.3 V
    localparam int COEF_W = 18;   // 0.5 .. 2.1
    localparam int CV_W   = 19;   // up to 6.6 V

    // volts = adc * 3.3 * 2^16 / full, numerator 33 * 2^16 over 10 * full
    localparam int VOLT_NUM   = 33 * 65536;
    localparam int VOLT_NUM_W = 22;

    // coefficient = 0.5 + t / 500 in Q.16, t * 2^16 / 500 = t * 2^14 / 125
    localparam logic [COEF_W-1:0] COEF_HALF = 18'd32768;
    localparam int TEMP_SCALE_SHIFT = 14;
    localparam int TEMP_DEN         = 125;
    localparam int TEMP_RECIP_W     = 18;
    localparam int TEMP_RECIP_SHIFT = 10;
    localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = 18'd134217;  // 2^24 / 125

    // pipelined restoring divider
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = 10;
    localparam int DIV_Q_W    = DIV_STEPS * DIV_STAGES;

    // cubic
    localparam int POLY_A_W = 24;
    localparam int POLY_B_W = 24;
    localparam int POLY_C_W = 26;
    localparam logic [POLY_A_W-1:0] POLY_A = 24'd8743813;
    localparam logic [POLY_B_W-1:0] POLY_B = 24'd16768041;
    localparam logic [POLY_C_W-1:0] POLY_C = 26'd56189911;

    localparam int SQ_W    = 2 * CV_W;
    localparam int X2_W    = SQ_W - FRAC_W;
    localparam int CUBE_W  = X2_W + CV_W;
    localparam int X3_W    = CUBE_W - FRAC_W;
    localparam int TA_W    = X3_W + POLY_A_W;
    localparam int TB_W    = X2_W + POLY_B_W;
    localparam int TC_W    = CV_W + POLY_C_W;
    localparam int POS_W   = TA_W + 1;
    localparam int RAW_W   = POS_W - FRAC_W;
    localparam int CALP_W  = RAW_W + CAL_W;
    localparam int CAL_SHIFT = 28;
    localparam int PPMF_W  = CALP_W - CAL_SHIFT;

    localparam int PPM_W = 20;
    localparam logic [PPMF_W-1:0] PPM_MAX = PPMF_W'(1048575);

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [CAL_W-1:0]  cal;
        logic              cal_defaulted;
    } t_cfg_derived;

endpackage

[design/tds_cfg.sv]
// ----------------------------------------------------------------------------
// tds_cfg: configuration registers and derived values
// Holds temperature and calibration, clamps the temperature, forms the Q.16
// compensation divisor and substitutes 1.0 for an out-of-range calibration.
// ----------------------------------------------------------------------------
module tds_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  tds_pkg::t_cfg_index          i_cfg_index,
    input  logic [tds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tds_pkg::t_cfg_derived        o_cfg
);

    localparam int TPROD_W  = tds_pkg::TEMP_W + tds_pkg::TEMP_RECIP_W;
    localparam int TSCALE_W = tds_pkg::TEMP_W + tds_pkg::TEMP_SCALE_SHIFT;

    logic [tds_pkg::TEMP_W-1:0] r_temp;
    logic [tds_pkg::CAL_W-1:0]  r_cal;

    logic [tds_pkg::TEMP_W-1:0] r_t_clamp, n_t_clamp;
    logic [TPROD_W-1:0]         r_t_prod, n_t_prod;
    logic [tds_pkg::CAL_W-1:0]  r_cal_eff, n_cal_eff;
    logic                       r_cal_def, n_cal_def;
    logic [tds_pkg::COEF_W-1:0] r_coef, n_coef;

    logic [tds_pkg::COEF_W-1:0] est;
    logic [TSCALE_W-1:0]        rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= tds_pkg::TEMP_RESET;
            r_cal  <= tds_pkg::CAL_ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tds_pkg::CFG_IDX_TEMP: begin
                    r_temp <= i_cfg_data[tds_pkg::TEMP_W-1:0];
                end
                tds_pkg::CFG_IDX_CAL: begin
                    r_cal <= i_cfg_data[tds_pkg::CAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_t_clamp = (r_temp > tds_pkg::TEMP_MAX) ? tds_pkg::TEMP_MAX : r_temp;
        n_t_prod  = TPROD_W'(n_t_clamp) * TPROD_W'(tds_pkg::TEMP_RECIP);
        n_cal_def = (r_cal == '0) || (r_cal > tds_pkg::CAL_MAX);
        n_cal_eff = n_cal_def ? tds_pkg::CAL_ONE : r_cal;
    end

    // reciprocal estimate is low by at most one: fix with one compare
    always_comb begin
        est = r_t_prod[tds_pkg::TEMP_RECIP_SHIFT +: tds_pkg::COEF_W];
        rem = {r_t_clamp, {tds_pkg::TEMP_SCALE_SHIFT{1'b0}}}
            - TSCALE_W'(est) * TSCALE_W'(tds_pkg::TEMP_DEN);
        n_coef = tds_pkg::COEF_HALF + est
               + tds_pkg::COEF_W'(rem >= TSCALE_W'(tds_pkg::TEMP_DEN));
    end

    // registered: clamped temperature, product and calibration check, then the coefficient
    always_ff @(posedge i_clk) begin
        r_t_clamp <= n_t_clamp;
        r_t_prod  <= n_t_prod;
        r_cal_def <= n_cal_def;
        r_cal_eff <= n_cal_eff;
        r_coef    <= n_coef;
    end

    assign o_cfg.coef          = r_coef;
    assign o_cfg.cal           = r_cal_eff;
    assign o_cfg.cal_defaulted = r_cal_def;

endmodule

[design/tds_volt.sv]
// ----------------------------------------------------------------------------
// tds_volt: ADC code to Q.16 volts
// Three stages: reciprocal multiply, back-multiply, one-step correction that
// yields the exact truncated quotient adc * 3.3 * 2^16 / full.
// ----------------------------------------------------------------------------
module tds_volt #(
    parameter int ADC_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ADC_BITS-1:0]          i_adc,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tds_pkg::VOLT_W-1:0]   o_volt
);

    localparam int NUM_W = ADC_BITS + tds_pkg::VOLT_NUM_W;
    localparam int P_W   = ADC_BITS + tds_pkg::VOLT_W;
    localparam logic [63:0] FULL  = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] DEN   = 64'd10 * FULL;
    localparam logic [63:0] RECIP = (64'(tds_pkg::VOLT_NUM) << ADC_BITS) / DEN;
    localparam logic [tds_pkg::VOLT_W-1:0] RECIP_K = RECIP[tds_pkg::VOLT_W-1:0];
    localparam logic [NUM_W-1:0] DEN_N = DEN[NUM_W-1:0];
    localparam logic [NUM_W-1:0] NUM_N = NUM_W'(tds_pkg::VOLT_NUM);

    logic                        r_s1_vld, r_s2_vld, r_s3_vld;
    logic                        en1, en2, en3;

    logic [ADC_BITS-1:0]         r_s1_adc;
    logic [P_W-1:0]              r_s1_p, n_s1_p;
    logic [tds_pkg::VOLT_W-1:0]  r_s2_est, n_s2_est;
    logic [NUM_W-1:0]            r_s2_num, n_s2_num;
    logic [NUM_W-1:0]            r_s2_ed, n_s2_ed;
    logic [NUM_W-1:0]            rem;
    logic [tds_pkg::VOLT_W-1:0]  r_s3_volt, n_s3_volt;

    assign en3     = !r_s3_vld || i_ready;
    assign en2     = !r_s2_vld || en3;
    assign en1     = !r_s1_vld || en2;
    assign o_ready = en1;
    assign o_valid = r_s3_vld;
    assign o_volt  = r_s3_volt;

    always_comb begin
        n_s1_p    = P_W'(i_adc) * P_W'(RECIP_K);
        n_s2_est  = r_s1_p[ADC_BITS +: tds_pkg::VOLT_W];
        n_s2_num  = NUM_W'(r_s1_adc) * NUM_N;
        n_s2_ed   = NUM_W'(n_s2_est) * DEN_N;
        rem       = r_s2_num - r_s2_ed;
        // estimate is low by at most one
        n_s3_volt = (rem >= DEN_N) ? r_s2_est + tds_pkg::VOLT_W'(1) : r_s2_est;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_valid;
            if (en2) r_s2_vld <= r_s1_vld;
            if (en3) r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1_adc <= i_adc;
            r_s1_p   <= n_s1_p;
        end
        if (en2 && r_s1_vld) begin
            r_s2_est <= n_s2_est;
            r_s2_num <= n_s2_num;
            r_s2_ed  <= n_s2_ed;
        end
        if (en3 && r_s2_vld) begin
            r_s3_volt <= n_s3_volt;
        end
    end

endmodule

[design/tds_div.sv]
// ----------------------------------------------------------------------------
// tds_div: pipelined restoring divider for temperature compensation
// Computes floor(v * 2^16 / coef), a fixed number of quotient bits per stage,
// with per-stage valid bits and bubble-collapsing stall.
// ----------------------------------------------------------------------------
module tds_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tds_pkg::VOLT_W-1:0]   i_volt,
    input  logic [tds_pkg::COEF_W-1:0]   i_coef,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tds_pkg::CV_W-1:0]     o_cv
);

    localparam int S     = tds_pkg::DIV_STAGES;
    localparam int Q_W   = tds_pkg::DIV_Q_W;
    localparam int R_W   = tds_pkg::COEF_W;
    localparam int N_W   = tds_pkg::VOLT_W + tds_pkg::FRAC_W;

    logic [S-1:0]   r_vld;
    logic [S-1:0]   src_vld;
    logic [S:0]     en;
    logic [R_W-1:0] r_rem  [S];
    logic [Q_W-1:0] r_quo  [S];
    logic [Q_W-1:0] r_bits [S];
    logic [R_W-1:0] n_rem  [S];
    logic [Q_W-1:0] n_quo  [S];
    logic [Q_W-1:0] n_bits [S];
    logic [R_W-1:0] src_rem  [S];
    logic [Q_W-1:0] src_quo  [S];
    logic [Q_W-1:0] src_bits [S];
    logic [N_W-1:0] dividend;

    assign dividend = {i_volt, {tds_pkg::FRAC_W{1'b0}}};
    assign src_vld  = {r_vld[S-2:0], i_valid};

    always_comb begin
        // quotient fits in Q_W bits, so the top part is below the divisor
        src_rem[0]  = R_W'(dividend[N_W-1:Q_W]);
        src_quo[0]  = '0;
        src_bits[0] = dividend[Q_W-1:0];
        for (int s = 1; s < S; s++) begin
            src_rem[s]  = r_rem[s-1];
            src_quo[s]  = r_quo[s-1];
            src_bits[s] = r_bits[s-1];
        end
    end

    always_comb begin
        logic [R_W-1:0] rem;
        logic [Q_W-1:0] quo;
        logic [Q_W-1:0] bits;
        logic [R_W:0]   trial;
        for (int s = 0; s < S; s++) begin
            rem  = src_rem[s];
            quo  = src_quo[s];
            bits = src_bits[s];
            for (int j = 0; j < tds_pkg::DIV_STEPS; j++) begin
                trial = {rem, bits[Q_W-1]};
                bits  = {bits[Q_W-2:0], 1'b0};
                if (trial >= {1'b0, i_coef}) begin
                    rem = R_W'(trial - {1'b0, i_coef});
                    quo = {quo[Q_W-2:0], 1'b1};
                end else begin
                    rem = trial[R_W-1:0];
                    quo = {quo[Q_W-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_quo[s]  = quo;
            n_bits[s] = bits;
        end
    end

    always_comb begin
        en[S] = i_ready;
        for (int s = S - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < S; s++) begin
                if (en[s]) r_vld[s] <= src_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < S; s++) begin
            if (en[s] && src_vld[s]) begin
                r_rem[s]  <= n_rem[s];
                r_quo[s]  <= n_quo[s];
                r_bits[s] <= n_bits[s];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[S-1];
    assign o_cv    = r_quo[S-1][tds_pkg::CV_W-1:0];

endmodule

[design/tds_poly.sv]
// ----------------------------------------------------------------------------
// tds_poly: cubic evaluation, calibration and output register
// Eight stages, at most one multiplier per stage; the last stage is the
// output register and holds a finished item until it is taken.
// ----------------------------------------------------------------------------
module tds_poly (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tds_pkg::CV_W-1:0]     i_cv,
    input  tds_pkg::t_cfg_derived        i_cfg,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tds_pkg::PPM_W-1:0]    o_ppm,
    output logic                         o_defaulted
);

    localparam int S = 8;

    logic [S-1:0] r_vld;
    logic [S-1:0] src_vld;
    logic [S:0]   en;

    logic [tds_pkg::SQ_W-1:0]   sq;
    logic [tds_pkg::CUBE_W-1:0] cube;
    logic [tds_pkg::POS_W-1:0]  diff;

    logic [tds_pkg::CV_W-1:0]   r_s0_cv, r_s1_cv, r_s2_cv;
    logic [tds_pkg::X2_W-1:0]   r_s0_x2, r_s1_x2, r_s2_x2, r_s3_x2;
    logic [tds_pkg::X3_W-1:0]   r_s1_x3;
    logic [tds_pkg::TA_W-1:0]   r_s2_ta, r_s3_ta, n_s2_ta;
    logic [tds_pkg::TC_W-1:0]   r_s3_tc, n_s3_tc;
    logic [tds_pkg::TB_W-1:0]   r_s4_tb, n_s4_tb;
    logic [tds_pkg::POS_W-1:0]  r_s4_pos, n_s4_pos;
    logic [tds_pkg::RAW_W-1:0]  r_s5_raw, n_s5_raw;
    logic [tds_pkg::CALP_W-1:0] r_s6_prod, n_s6_prod;
    logic                       r_s6_def, r_s7_def;
    logic [tds_pkg::PPMF_W-1:0] ppm_full;
    logic [tds_pkg::PPM_W-1:0]  r_s7_ppm, n_s7_ppm;

    assign src_vld = {r_vld[S-2:0], i_valid};

    always_comb begin
        en[S] = i_ready;
        for (int s = S - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_comb begin
        sq        = tds_pkg::SQ_W'(i_cv) * tds_pkg::SQ_W'(i_cv);
        cube      = tds_pkg::CUBE_W'(r_s0_x2) * tds_pkg::CUBE_W'(r_s0_cv);
        n_s2_ta   = tds_pkg::TA_W'(r_s1_x3) * tds_pkg::TA_W'(tds_pkg::POLY_A);
        n_s3_tc   = tds_pkg::TC_W'(r_s2_cv) * tds_pkg::TC_W'(tds_pkg::POLY_C);
        n_s4_tb   = tds_pkg::TB_W'(r_s3_x2) * tds_pkg::TB_W'(tds_pkg::POLY_B);
        n_s4_pos  = tds_pkg::POS_W'(r_s3_ta) + tds_pkg::POS_W'(r_s3_tc);
        diff      = r_s4_pos - tds_pkg::POS_W'(r_s4_tb);
        // clamp a negative cubic to zero
        n_s5_raw  = (r_s4_pos > tds_pkg::POS_W'(r_s4_tb))
                  ? diff[tds_pkg::POS_W-1:tds_pkg::FRAC_W] : '0;
        n_s6_prod = tds_pkg::CALP_W'(r_s5_raw) * tds_pkg::CALP_W'(i_cfg.cal);
        ppm_full  = r_s6_prod[tds_pkg::CALP_W-1:tds_pkg::CAL_SHIFT];
        n_s7_ppm  = (ppm_full > tds_pkg::PPM_MAX)
                  ? tds_pkg::PPM_MAX[tds_pkg::PPM_W-1:0] : ppm_full[tds_pkg::PPM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < S; s++) begin
                if (en[s]) r_vld[s] <= src_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0] && src_vld[0]) begin
            r_s0_cv <= i_cv;
            r_s0_x2 <= sq[tds_pkg::SQ_W-1:tds_pkg::FRAC_W];
        end
        if (en[1] && src_vld[1]) begin
            r_s1_cv <= r_s0_cv;
            r_s1_x2 <= r_s0_x2;
            r_s1_x3 <= cube[tds_pkg::CUBE_W-1:tds_pkg::FRAC_W];
        end
        if (en[2] && src_vld[2]) begin
            r_s2_cv <= r_s1_cv;
            r_s2_x2 <= r_s1_x2;
            r_s2_ta <= n_s2_ta;
        end
        if (en[3] && src_vld[3]) begin
            r_s3_x2 <= r_s2_x2;
            r_s3_ta <= r_s2_ta;
            r_s3_tc <= n_s3_tc;
        end
        if (en[4] && src_vld[4]) begin
            r_s4_pos <= n_s4_pos;
            r_s4_tb  <= n_s4_tb;
        end
        if (en[5] && src_vld[5]) begin
            r_s5_raw <= n_s5_raw;
        end
        if (en[6] && src_vld[6]) begin
            r_s6_prod <= n_s6_prod;
            r_s6_def  <= i_cfg.cal_defaulted;
        end
        if (en[7] && src_vld[7]) begin
            r_s7_ppm <= n_s7_ppm;
            r_s7_def <= r_s6_def;
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_vld[S-1];
    assign o_ppm       = r_s7_ppm;
    assign o_defaulted = r_s7_def;

endmodule

[design/tds_ppm_from_adc.sv]
// ----------------------------------------------------------------------------
// tds_ppm_from_adc: TDS probe ADC sample to ppm converter
// Scales a sample to volts, compensates for water temperature, evaluates the
// probe cubic, applies calibration and truncates to whole ppm.
// ----------------------------------------------------------------------------
// One sample can enter per cycle unless the pipeline is full and stalled:
// 3 stages of voltage scaling, 10 stages of the compensation divider
// (2 quotient bits each) and 8 stages of cubic, calibration and output
// register. Each stage stalls on its own, so a waiting result does not stop
// new samples until the pipeline is full. Register writes take effect through
// the registered derived values; a calibration of zero or above 10.0 is
// replaced by 1.0 and flagged on o_calibration_defaulted, and temperatures
// above 80.0 C are taken as 80.0 C.
// ----------------------------------------------------------------------------
module tds_ppm_from_adc #(
    parameter int ADC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ADC_BITS-1:0]            i_adc_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tds_pkg::PPM_W-1:0]      o_tds_ppm,
    output logic                           o_calibration_defaulted
);

    tds_pkg::t_cfg_derived            w_cfg;
    logic                             w_volt_valid, w_volt_ready;
    logic [tds_pkg::VOLT_W-1:0]       w_volt;
    logic                             w_cv_valid, w_cv_ready;
    logic [tds_pkg::CV_W-1:0]         w_cv;

    tds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (tds_pkg::t_cfg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tds_volt #(
        .ADC_BITS (ADC_BITS)
    ) u_volt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_adc   (i_adc_sample),
        .o_valid (w_volt_valid),
        .i_ready (w_volt_ready),
        .o_volt  (w_volt)
    );

    tds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_volt_valid),
        .o_ready (w_volt_ready),
        .i_volt  (w_volt),
        .i_coef  (w_cfg.coef),
        .o_valid (w_cv_valid),
        .i_ready (w_cv_ready),
        .o_cv    (w_cv)
    );

    tds_poly u_poly (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cv_valid),
        .o_ready     (w_cv_ready),
        .i_cv        (w_cv),
        .i_cfg       (w_cfg),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_ppm       (o_tds_ppm),
        .o_defaulted (o_calibration_defaulted)
    );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the TDS ppm converter
// Sends ADC samples and register writes with random gaps and output stalls,
// predicts every ppm reading in fixed point and compares it with the converter.
// ----------------------------------------------------------------------------
module testbench;
    import tds_pkg::*;

    localparam int ADC_BITS = 12;
    localparam longint unsigned ADC_FULL = (64'd1 << ADC_BITS) - 1;

    localparam int TEMP_RESET_TENTHS = 250;
    localparam int TEMP_LIMIT        = 800;
    localparam int CAL_UNITY         = 4096;
    localparam int CAL_LIMIT         = 40960;

    // probe cubic coefficients in Q.16
    localparam longint unsigned CUBIC_X3 = 8743813;
    localparam longint unsigned CUBIC_X2 = 16768041;
    localparam longint unsigned CUBIC_X1 = 56189911;
    localparam longint unsigned PPM_CEIL = 1048575;

    localparam int LATENCY         = 21;
    localparam int DRAIN_CYCLES    = 3 * LATENCY;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int BURST_ITEMS     = 40;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 70;
    localparam int MAX_GAP         = 6;

    localparam t_cfg_index CFG_IDX_FIRST_SPARE = t_cfg_index'(2);
    localparam t_cfg_index CFG_IDX_LAST        = '1;

    typedef struct {
        logic [PPM_W-1:0] tds_ppm;
        logic             calibration_defaulted;
    } t_ppm_reading;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [ADC_BITS-1:0]   adc       = '0;
    logic                  out_ready = 1'b0;

    logic             cfg_ready;
    logic             in_ready;
    logic             out_valid;
    logic [PPM_W-1:0] tds_ppm;
    logic             cal_defaulted;

    // register copies as the converter should hold them
    logic [TEMP_W-1:0] temp_reg = TEMP_W'(TEMP_RESET_TENTHS);
    logic [CAL_W-1:0]  cal_reg  = CAL_W'(CAL_UNITY);

    t_ppm_reading readings_due[$];
    int           mismatch_count    = 0;
    bit           tx_gaps_on        = 1'b1;
    bit           rx_gaps_on        = 1'b1;
    int           hold_off_request  = 0;

    tds_ppm_from_adc #(
        .ADC_BITS(ADC_BITS)
    ) DUT (
        .i_clk                   (clk),
        .i_rst_n                 (rst_n),
        .i_cfg_valid             (cfg_valid),
        .o_cfg_ready             (cfg_ready),
        .i_cfg_index             (cfg_index),
        .i_cfg_data              (cfg_data),
        .i_in_valid              (in_valid),
        .o_in_ready              (in_ready),
        .i_adc_sample            (adc),
        .o_out_valid             (out_valid),
        .i_out_ready             (out_ready),
        .o_tds_ppm               (tds_ppm),
        .o_calibration_defaulted (cal_defaulted)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_ppm_reading predict_reading(input logic [ADC_BITS-1:0] sample,
                                                     input logic [TEMP_W-1:0] temp_tenths,
                                                     input logic [CAL_W-1:0] cal_q12);
        longint unsigned volts, coef, comp, sq, cube, pos, neg, poly, scaled;
        longint unsigned temp_used, cal_used;
        t_ppm_reading reading;
        temp_used = (temp_tenths > TEMP_LIMIT) ? TEMP_LIMIT : temp_tenths;
        reading.calibration_defaulted = (cal_q12 == 0) || (cal_q12 > CAL_LIMIT);
        cal_used = reading.calibration_defaulted ? CAL_UNITY : cal_q12;

        volts = sample;
        volts = (volts * 33 * 65536) / (10 * ADC_FULL);
        coef  = 32768 + (temp_used * 65536) / 500;
        comp  = (volts << 16) / coef;
        sq    = (comp * comp) >> 16;
        cube  = (sq * comp) >> 16;
        pos   = CUBIC_X3 * cube + CUBIC_X1 * comp;
        neg   = CUBIC_X2 * sq;
        // clamp at zero if truncation pushes the cubic negative
        poly  = (pos > neg) ? ((pos - neg) >> 16) : 0;
        scaled = (poly * cal_used) >> 28;
        if (scaled > PPM_CEIL) begin
            scaled = PPM_CEIL;
        end
        reading.tds_ppm = scaled[PPM_W-1:0];
        return reading;
    endfunction

    task automatic write_reg(input t_cfg_index index, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (index == CFG_IDX_TEMP) begin
            temp_reg = data[TEMP_W-1:0];
        end else if (index == CFG_IDX_CAL) begin
            cal_reg = data[CAL_W-1:0];
        end
    endtask

    task automatic end_writes;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [ADC_BITS-1:0] sample);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc      <= sample;
        do @(posedge clk); while (in_ready !== 1'b1);
        readings_due.push_back(predict_reading(sample, temp_reg, cal_reg));
    endtask

    task automatic stop_samples;
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle;
        do @(posedge clk); while (readings_due.size() != 0);
    endtask

    // drain the pipeline, then load both registers
    task automatic set_config(input logic [CFG_DATA_W-1:0] temp_data,
                              input logic [CFG_DATA_W-1:0] cal_data);
        stop_samples();
        wait_idle();
        write_reg(CFG_IDX_TEMP, temp_data);
        write_reg(CFG_IDX_CAL, cal_data);
        end_writes();
    endtask

    task automatic test_sample_extremes;
        logic [ADC_BITS-1:0] samples[8];
        samples = '{12'd0, 12'd1, 12'd2047, 12'd2048, 12'hAAA, 12'h555, 12'd4094, 12'd4095};
        foreach (samples[i]) begin
            send_sample(samples[i]);
        end
        stop_samples();
    endtask

    task automatic test_temperature_range;
        logic [CFG_DATA_W-1:0] temps[3];
        // 1023 lies above the limit and must be clamped to 80.0 C
        temps = '{16'd0, 16'd800, 16'd1023};
        foreach (temps[i]) begin
            set_config(temps[i], CFG_DATA_W'(CAL_UNITY));
            send_sample(12'd4095);
            send_sample(12'd1234);
        end
        stop_samples();
    endtask

    task automatic test_calibration_range;
        logic [CFG_DATA_W-1:0] cals[5];
        cals = '{16'd0, 16'd1, 16'd40960, 16'd40961, 16'hFFFF};
        foreach (cals[i]) begin
            set_config(CFG_DATA_W'(TEMP_RESET_TENTHS), cals[i]);
            send_sample(12'd4095);
        end
        stop_samples();
    endtask

    task automatic test_spare_indexes;
        logic [CFG_DATA_W-1:0] data;
        set_config(16'd123, 16'd5000);
        for (int idx = CFG_IDX_FIRST_SPARE; idx <= CFG_IDX_LAST; idx++) begin
            data = idx[0] ? 16'hFFFF : CFG_DATA_W'($urandom);
            write_reg(t_cfg_index'(idx), data);
        end
        end_writes();
        // registers must still hold the values loaded above
        send_sample(12'd3000);
        send_sample(12'd700);
        stop_samples();
    endtask

    task automatic test_output_backpressure;
        bit saved_gaps;
        saved_gaps = tx_gaps_on;
        set_config(16'd400, 16'd8192);
        tx_gaps_on = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (BURST_ITEMS) begin
            send_sample(ADC_BITS'($urandom));
        end
        stop_samples();
        tx_gaps_on = saved_gaps;
    endtask

    task automatic test_random_samples;
        logic [CFG_DATA_W-1:0] temp_data, cal_data;
        logic [ADC_BITS-1:0]   sample;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    temp_data = 16'd0;
                    cal_data  = 16'd40960;
                end
                1: begin
                    temp_data = 16'd800;
                    cal_data  = 16'd1;
                end
                2: begin
                    temp_data = 16'hFFFF;
                    cal_data  = 16'd0;
                end
                3: begin
                    temp_data = 16'd801;
                    cal_data  = 16'hFFFF;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        temp_data = CFG_DATA_W'($urandom);
                    end else begin
                        temp_data = CFG_DATA_W'($urandom_range(0, TEMP_LIMIT));
                    end
                    case ($urandom_range(0, 5))
                        0: cal_data = 16'd0;
                        1: cal_data = CFG_DATA_W'($urandom_range(CAL_LIMIT + 1, 65535));
                        default: cal_data = CFG_DATA_W'($urandom_range(1, CAL_LIMIT));
                    endcase
                end
            endcase
            set_config(temp_data, cal_data);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0: sample = '0;
                    1: sample = '1;
                    default: sample = ADC_BITS'($urandom);
                endcase
                send_sample(sample);
            end
            stop_samples();
        end
        rx_gaps_on = 1'b1;
    endtask

    // receiver: random stall before each item, plus one long hold-off on request
    initial begin : reading_sink
        int stall;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_off_request != 0) begin
                stall = hold_off_request;
                hold_off_request = 0;
            end else begin
                stall = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin : reading_check
        t_ppm_reading want;
        if (rst_n && out_ready && out_valid === 1'b1) begin
            if (readings_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected item: ppm=%0d defaulted=%b", tds_ppm, cal_defaulted);
                end
            end else begin
                want = readings_due.pop_front();
                if (tds_ppm !== want.tds_ppm ||
                    cal_defaulted !== want.calibration_defaulted) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: ppm exp=%0d got=%0d, defaulted exp=%b got=%b",
                                 want.tds_ppm, tds_ppm, want.calibration_defaulted,
                                 cal_defaulted);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (cfg_valid && cfg_ready === 1'b1) ||
                (out_ready && out_valid === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_sample_extremes();
        test_temperature_range();
        test_calibration_range();
        test_spare_indexes();
        test_output_backpressure();
        test_random_samples();
        stop_samples();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && readings_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
